@@ hdl/ipbl_pkg.sv @@
// shared types and constants of the process / ip / port blocklist matcher
`timescale 1ns / 1ps

package ipbl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // fixed field widths
    localparam int NAME_W      = 64;
    localparam int IP_W        = 32;
    localparam int PLEN_W      = 6;
    localparam int PORT_W      = 16;
    localparam int SLOT_W      = 9;
    localparam int FULL_PREFIX = 32;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // one table entry
    typedef struct packed {
        logic [NAME_W-1:0] name_high;
        logic [NAME_W-1:0] name_low;
        logic [IP_W-1:0]   net;
        logic [PLEN_W-1:0] plen;
        logic [PORT_W-1:0] port;
    } t_entry;

    // search key latched from each accepted request word
    typedef struct packed {
        logic [NAME_W-1:0] name_high;
        logic [NAME_W-1:0] name_low;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } t_key;

    // table access from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

@@ hdl/process_ip_port_blocklist_match.sv @@
// top level of the process / ipv4 network / port blocklist matcher
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-----------------------------------------
//  request  | in        | i_valid / o_stall  | action, slot, name, ip, prefix, port
//  result   | out       | o_valid / i_stall  | blocked, match index
//
// a write word is answered in the next cycle; a check ends at the first matching
// slot, or after slot TABLE_DEPTH - 1 when nothing matches, as the single table read
// port and the one shared compare unit walk the slots in order.
// after reset a clearing pass over all TABLE_DEPTH slots zeroes the table, o_stall high.
// a new word is taken only once the previous result has left the output register.
`timescale 1ns / 1ps

module process_ip_port_blocklist_match
    import ipbl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [NAME_W-1:0] i_name_high,
    input  logic [NAME_W-1:0] i_name_low,
    input  logic [IP_W-1:0]   i_dest_ip,
    input  logic [PLEN_W-1:0] i_prefix_len,
    input  logic [PORT_W-1:0] i_dest_port,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_blocked,
    output logic [SLOT_W-1:0] o_match_index
);

    t_mem_req req;
    t_entry   rd_data;
    t_key     key;
    logic     hit;

    // sequencer
    ipbl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_name_high   (i_name_high),
        .i_name_low    (i_name_low),
        .i_dest_ip     (i_dest_ip),
        .i_prefix_len  (i_prefix_len),
        .i_dest_port   (i_dest_port),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_blocked     (o_blocked),
        .o_match_index (o_match_index),
        .o_req         (req),
        .o_key         (key),
        .i_hit         (hit)
    );

    // table
    ipbl_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    // compare unit
    ipbl_cmp u_cmp (
        .i_entry (rd_data),
        .i_key   (key),
        .o_hit   (hit)
    );

endmodule

@@ hdl/ipbl_mem.sv @@
// blocklist table memory, one write port and one registered read port
`timescale 1ns / 1ps

module ipbl_mem
    import ipbl_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/ipbl_cmp.sv @@
// shared entry compare unit: name, masked network and port
`timescale 1ns / 1ps

module ipbl_cmp
    import ipbl_pkg::*;
(
    input  t_entry i_entry,
    input  t_key   i_key,
    output logic   o_hit
);

    logic [IP_W-1:0] mask;
    logic            name_eq;
    logic            net_eq;
    logic            port_eq;

    // prefix mask, zero length covers every address
    always_comb begin
        if (i_entry.plen == '0) begin
            mask = '0;
        end else begin
            mask = {IP_W{1'b1}} << (PLEN_W'(FULL_PREFIX) - i_entry.plen);
        end
    end

    // field compares
    assign name_eq = (i_entry.name_high == i_key.name_high) &&
                     (i_entry.name_low == i_key.name_low);
    assign net_eq  = ((i_entry.net ^ i_key.ip) & mask) == '0;
    assign port_eq = (i_entry.port == i_key.port);
    assign o_hit   = name_eq && net_eq && port_eq;

endmodule

@@ hdl/ipbl_ctrl.sv @@
// sequencer: clearing pass, table writes, in-order scan and result register
`timescale 1ns / 1ps

module ipbl_ctrl
    import ipbl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [NAME_W-1:0] i_name_high,
    input  logic [NAME_W-1:0] i_name_low,
    input  logic [IP_W-1:0]   i_dest_ip,
    input  logic [PLEN_W-1:0] i_prefix_len,
    input  logic [PORT_W-1:0] i_dest_port,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_blocked,
    output logic [SLOT_W-1:0] o_match_index,
    output t_mem_req          o_req,
    output t_key              o_key,
    input  logic              i_hit
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx;
    t_key              r_key;
    logic              r_out_valid, n_out_valid;
    logic              r_blocked, n_blocked;
    logic [SLOT_W-1:0] r_match_idx, n_match_idx;

    logic              in_acc;
    logic              out_acc;
    logic              in_range;
    logic              scan_done;
    logic [PLEN_W-1:0] plen_sat;

    // handshake
    assign o_stall   = !((r_state == ST_IDLE) && !r_out_valid);
    assign in_acc    = i_valid && !o_stall;
    assign out_acc   = r_out_valid && !i_stall;
    assign in_range  = 32'(i_entry_index) < TABLE_DEPTH;
    assign scan_done = r_pend && (i_hit || (r_pidx == LAST_IDX));
    assign plen_sat  = (i_prefix_len > PLEN_W'(FULL_PREFIX)) ?
                       PLEN_W'(FULL_PREFIX) : i_prefix_len;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr[IDX_W-1:0] == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && (i_action == ACT_CHECK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // table port and counters
    always_comb begin
        o_req       = '0;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !out_acc;
        n_blocked   = r_blocked;
        n_match_idx = r_match_idx;
        case (r_state)
            ST_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_addr[IDX_W-1:0];
                n_addr      = (r_addr[IDX_W-1:0] == LAST_IDX) ? '0 : r_addr + 1'b1;
            end
            ST_IDLE: begin
                n_addr = '0;
                if (in_acc) begin
                    if (i_action == ACT_WRITE) begin
                        o_req.we    = in_range;
                        o_req.waddr = IDX_W'(i_entry_index);
                        o_req.wdata = '{name_high: i_name_high, name_low: i_name_low,
                                        net: i_dest_ip, plen: plen_sat,
                                        port: i_dest_port};
                        n_out_valid = 1'b1;
                        n_blocked   = 1'b0;
                        n_match_idx = '0;
                    end
                end
            end
            ST_SCAN: begin
                o_req.re    = (r_addr < CNT_W'(TABLE_DEPTH)) && !scan_done;
                o_req.raddr = r_addr[IDX_W-1:0];
                if (o_req.re) begin
                    n_addr = r_addr + 1'b1;
                end
                n_pend = o_req.re;
                if (scan_done) begin
                    n_out_valid = 1'b1;
                    n_blocked   = i_hit;
                    n_match_idx = i_hit ? SLOT_W'(r_pidx) : '0;
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx      <= o_req.raddr;
        r_blocked   <= n_blocked;
        r_match_idx <= n_match_idx;
        if (in_acc) begin
            r_key <= '{name_high: i_name_high, name_low: i_name_low,
                       ip: i_dest_ip, port: i_dest_port};
        end
    end

    assign o_key         = r_key;
    assign o_valid       = r_out_valid;
    assign o_blocked     = r_blocked;
    assign o_match_index = r_match_idx;

endmodule

@@ hdl/ipbl_checker.sv @@
// port-level checks of the blocklist matcher and their binding
`timescale 1ns / 1ps

module ipbl_checker
    import ipbl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_action,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_blocked,
    input logic [SLOT_W-1:0] o_match_index
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blocked) && $stable(o_match_index))
        else $error("result word changed while stalled");

    // no new request while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");

    // a write answers in the next cycle with pass and index zero
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_WRITE)
        |=> o_valid && !o_blocked && (o_match_index == '0))
        else $error("write result wrong");

    // pass results carry index zero
    a_pass_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_blocked |-> (o_match_index == '0))
        else $error("pass result with nonzero index");

endmodule

bind process_ip_port_blocklist_match ipbl_checker u_ipbl_checker (.*);
